// File: design/mexp_pkg.sv
package mexp_pkg;

    // control from the sequencer to one modular multiply unit
    typedef struct packed {
        logic clear;  // zero the accumulator
        logic step;   // take one multiplier bit
        logic mbit;   // multiplier bit, most significant first
    } t_mul_ctrl;

endpackage

// File: design/mexp_mmul.sv
module mexp_mmul
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  t_mul_ctrl        i_ctrl,
    input  logic [WIDTH-1:0] i_mcand,
    input  logic [WIDTH-1:0] i_mod,
    output logic [WIDTH-1:0] o_acc
);

    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH+1:0] w_sum;
    logic [WIDTH+1:0] w_mod1;
    logic [WIDTH+1:0] w_mod2;
    logic [WIDTH+1:0] w_sub1;
    logic [WIDTH+1:0] w_sub2;

    // double the accumulator and add the multiplicand when the bit is set;
    // the sum stays below three times the modulus
    assign w_sum  = {1'b0, r_acc, 1'b0} + (i_ctrl.mbit ? {2'b00, i_mcand} : '0);
    assign w_mod1 = {2'b00, i_mod};
    assign w_mod2 = {1'b0, i_mod, 1'b0};
    assign w_sub1 = w_sum - w_mod1;
    assign w_sub2 = w_sum - w_mod2;

    // zero on clear; on a step, pick the one reduced candidate that lies below the modulus
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.step) begin
            if (w_sum >= w_mod2) begin
                n_acc = w_sub2[WIDTH-1:0];
            end else if (w_sum >= w_mod1) begin
                n_acc = w_sub1[WIDTH-1:0];
            end else begin
                n_acc = w_sum[WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// File: design/modular_exponentiation.sv
// channel   direction  handshake                     payload
// input     in         i_in_valid / o_in_stall       i_base_in   [31:0]
// output    out        o_out_valid / i_out_stall     o_power_out [31:0]
// config    apb        psel, penable, pwrite, pready paddr [2:0], pwdata, prdata
//
// for a nonzero modulus, one multiplier bit a cycle goes through the shift
// register, first to reduce the base and then for each of the WIDTH exponent
// bits, where squaring and the conditional multiply share the multiplier bits
// and run side by side; a zero modulus gives zero without computing.
// the input stalls from the cycle after an accept until the result is
// placed in the output register; a waiting result does not block the next item.
// reset is synchronous and active low: exponent 0, modulus 1, no item held.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_base_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_power_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic REG_EXP = 1'b0;
    localparam logic REG_MOD = 1'b1;

    logic [2:0]       r_state, n_state;
    logic [WIDTH-1:0] r_exp, n_exp;
    logic [WIDTH-1:0] r_mod, n_mod;
    logic [WIDTH-1:0] r_b, n_b;
    logic [WIDTH-1:0] r_res, n_res;
    logic [WIDTH-1:0] r_sr, n_sr;
    logic [WIDTH-1:0] r_exp_sr, n_exp_sr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_ebit, n_ebit;
    logic             r_first, n_first;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out, n_out;

    logic [63:0]      w_wdata_ext;
    logic [63:0]      w_base_ext;
    logic [63:0]      w_res_ext;
    logic [63:0]      w_exp_ext;
    logic [63:0]      w_mod_ext;
    logic             w_wr;
    logic             w_in_acc;
    t_mul_ctrl        w_ctrl;
    logic [WIDTH-1:0] w_mcand0;
    logic [WIDTH-1:0] w_acc0;
    logic [WIDTH-1:0] w_acc1;

    // fields and registers are cut to the datapath width
    assign w_wdata_ext = 64'(pwdata);
    assign w_base_ext  = 64'(i_base_in);
    assign w_res_ext   = 64'(r_res);
    assign w_exp_ext   = 64'(r_exp);
    assign w_mod_ext   = 64'(r_mod);

    assign w_wr     = psel && penable && pwrite;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // apb side
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            REG_EXP: prdata = w_exp_ext[31:0];
            REG_MOD: prdata = w_mod_ext[31:0];
            default: prdata = '0;
        endcase
    end

    // multiply unit control
    assign w_ctrl.clear = (r_state == S_IDLE) || (r_state == S_LOAD);
    assign w_ctrl.step  = (r_state == S_RED) || (r_state == S_MUL);
    assign w_ctrl.mbit  = r_sr[WIDTH-1];
    // the base is reduced as base times one
    assign w_mcand0     = (r_state == S_RED) ? WIDTH'(1) : r_b;

    // unit 0 reduces the base, then squares it
    mexp_mmul #(.WIDTH(WIDTH)) u_sq (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_mcand (w_mcand0),
        .i_mod   (r_mod),
        .o_acc   (w_acc0)
    );

    // unit 1 forms result times base
    mexp_mmul #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_mcand (r_res),
        .i_mod   (r_mod),
        .o_acc   (w_acc1)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_mod       = r_mod;
        n_b         = r_b;
        n_res       = r_res;
        n_sr        = r_sr;
        n_exp_sr    = r_exp_sr;
        n_cnt       = r_cnt;
        n_ebit      = r_ebit;
        n_first     = r_first;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (w_wr) begin
            unique case (paddr[2])
                REG_EXP: n_exp = w_wdata_ext[WIDTH-1:0];
                REG_MOD: n_mod = w_wdata_ext[WIDTH-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state) inside
            S_IDLE: begin
                if (w_in_acc) begin
                    n_sr     = w_base_ext[WIDTH-1:0];
                    n_exp_sr = r_exp;
                    n_cnt    = '0;
                    n_ebit   = '0;
                    n_first  = 1'b1;
                    if (r_mod == '0) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_res   = (r_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
                        n_state = S_RED;
                    end
                end
            end
            S_RED, S_MUL: begin
                n_sr  = {r_sr[WIDTH-2:0], 1'b0};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_b     = w_acc0;
                n_sr    = w_acc0;
                n_first = 1'b0;
                n_state = S_MUL;
                if (!r_first) begin
                    if (r_exp_sr[0]) begin
                        n_res = w_acc1;
                    end
                    n_exp_sr = {1'b0, r_exp_sr[WIDTH-1:1]};
                    n_ebit   = r_ebit + CW'(1);
                    if (r_ebit == LAST) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = w_res_ext[31:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= '0;
            r_mod       <= WIDTH'(1);
            r_cnt       <= '0;
            r_ebit      <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exp       <= n_exp;
            r_mod       <= n_mod;
            r_cnt       <= n_cnt;
            r_ebit      <= n_ebit;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_b      <= n_b;
        r_res    <= n_res;
        r_sr     <= n_sr;
        r_exp_sr <= n_exp_sr;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_power_out = r_out;

endmodule

// File: design/mexp_check.sv
module mexp_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_power_out
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an accepted item keeps the input stalled for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a result cannot show up in the cycle right after its item
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // a new result frees the input side at once
    a_free_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("input still stalled after result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_power_out)))
        else $error("stalled result changed");

endmodule

bind modular_exponentiation mexp_check u_mexp_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_power_out (o_power_out)
);

// File: sim/tb_modular_exponentiation.sv
module tb_modular_exponentiation;
    import mexp_pkg::*;

    // register byte addresses
    localparam logic [2:0] ADDR_EXP = 3'd0;
    localparam logic [2:0] ADDR_MOD = 3'd4;

    // generous bound: every item waiting out the longest gap and stall
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int ITEMS_PER_CFG = 10;
    localparam int CFGS_PER_MODE = 7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_base_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_power_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the configuration
    logic [31:0] cur_exp;
    logic [31:0] cur_mod;

    logic [31:0] power_q[$];
    int          error_count;
    int          powers_checked;
    int          bases_sent;
    int          cycle_count;
    int          idle_pct;
    int          stall_pct;
    int          stall_run;

    modular_exponentiation u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_base_in   (i_base_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_power_out (o_power_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     power_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // base ^ exponent mod modulus with exact 64-bit products
    function automatic logic [31:0] predict_power(input logic [31:0] base);
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] sq;
        if (cur_mod == 32'd0) begin
            return 32'd0;
        end
        m   = {32'd0, cur_mod};
        sq  = {32'd0, base} % m;
        acc = 64'd1 % m;
        for (int i = 0; i < 32; i++) begin
            if (cur_exp[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[31:0];
    endfunction

    // result checker
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (power_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_power_out);
                error_count++;
            end else begin
                want = power_q.pop_front();
                powers_checked++;
                if (o_power_out !== want) begin
                    $display("%0t: power_out mismatch: expected %h, actual %h",
                             $time, want, o_power_out);
                    error_count++;
                end
            end
        end
    end

    // receiver stall runs, mostly short with an occasional long hold
    initial begin
        i_out_stall = 1'b0;
        stall_run = 0;
        forever begin
            @(negedge i_clk);
            if (stall_run > 0) begin
                stall_run--;
            end else begin
                i_out_stall = ($urandom_range(99) < stall_pct);
                stall_run = ($urandom_range(9) == 0) ? $urandom_range(1, 1500)
                                                     : $urandom_range(1, 8);
            end
        end
    end

    // one apb write, starting at a falling edge
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == ADDR_EXP) begin
            cur_exp = data;
        end else if (addr == ADDR_MOD) begin
            cur_mod = data;
        end
    endtask

    // one apb read, compared with the register value
    task automatic cfg_read_check(input logic [2:0] addr, input logic [31:0] want);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: readback at %h: expected %h, actual %h", $time, addr, want,
                     prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // block idle: wait until every expected result has come back
    task automatic wait_drain();
        while (power_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // set both registers and read them back
    task automatic set_key(input logic [31:0] exp_v, input logic [31:0] mod_v);
        wait_drain();
        cfg_write(ADDR_EXP, exp_v);
        cfg_write(ADDR_MOD, mod_v);
        cfg_read_check(ADDR_EXP, exp_v);
        cfg_read_check(ADDR_MOD, mod_v);
    endtask

    // send one base item, starting at a falling edge
    task automatic send_base(input logic [31:0] base);
        i_in_valid = 1'b1;
        i_base_in = base;
        do @(posedge i_clk); while (o_in_stall);
        power_q.push_back(predict_power(base));
        bases_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        if ($urandom_range(99) < idle_pct) begin
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 1200)) @(negedge i_clk);
            end else begin
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    endtask

    // modulus: any value, tiny, near the top, or around a power of two
    function automatic logic [31:0] rand_mod();
        logic [31:0] m;
        case ($urandom_range(3))
            0: m = $urandom();
            1: m = $urandom_range(1, 255);
            2: m = 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: m = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 1);
        endcase
        return (m == 32'd0) ? 32'd1 : m;
    endfunction

    function automatic logic [31:0] rand_exp();
        case ($urandom_range(4))
            0: return $urandom_range(0, 16);
            1: return 32'hFFFF_FFFF;
            2: return 32'd65537;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_base();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return cur_mod - 32'd1;
            3: return cur_mod;
            default: return $urandom();
        endcase
    endfunction

    // registers come out of reset as exponent 0, modulus 1
    task automatic test_reset_values();
        cfg_read_check(ADDR_EXP, 32'd0);
        cfg_read_check(ADDR_MOD, 32'd1);
        send_base(32'd0);
        send_base(32'hFFFF_FFFF);
    endtask

    // exponent and modulus extremes and a few textbook keys
    task automatic test_corner_keys();
        set_key(32'd0, 32'd1000);
        send_base(32'd7);
        set_key(32'd1, 32'hFFFF_FFFF);
        send_base(32'hFFFF_FFFF);
        send_base(32'hFFFF_FFFE);
        send_base(32'd0);
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_base(32'hFFFF_FFFE);
        send_base(32'd2);
        send_base(32'hAAAA_AAAA);
        set_key(32'd65537, 32'hFFFF_FFFB);
        send_base(32'h5555_5555);
        send_base(32'd1);
        send_base(32'd0);
        set_key(32'd2, 32'd2);
        send_base(32'hFFFF_FFFF);
        send_base(32'd2);
        set_key(32'h8000_0000, 32'h8000_0000);
        send_base(32'd3);
        set_key(32'd3, 32'd33);
        send_base(32'd4);
    endtask

    // a zero modulus gives zero without computing
    task automatic test_modulus_zero();
        set_key(32'd12345, 32'd0);
        send_base(32'd9);
        send_base(32'hFFFF_FFFF);
    endtask

    // random keys and bases under one idling pattern
    task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        for (int c = 0; c < CFGS_PER_MODE; c++) begin
            set_key(rand_exp(), rand_mod());
            for (int k = 0; k < ITEMS_PER_CFG; k++) begin
                send_base(rand_base());
            end
        end
    endtask

    // stimulus sequence
    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_base_in = 32'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_EXP;
        pwdata = 32'd0;
        cur_exp = 32'd0;
        cur_mod = 32'd1;
        error_count = 0;
        powers_checked = 0;
        bases_sent = 0;
        cycle_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_corner_keys();
        test_modulus_zero();
        test_random_traffic(0, 0);
        test_random_traffic(50, 0);
        test_random_traffic(0, 50);
        test_random_traffic(8, 8);

        // let any stray result show up
        wait_drain();
        stall_pct = 0;
        repeat (1200) @(posedge i_clk);

        $display("sent %0d bases, checked %0d powers over corner and random keys,",
                 bases_sent, powers_checked);
        $display("zero modulus, and sender idle / receiver stall mixes");
        if (error_count == 0 && power_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results missing", error_count, power_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
